/* hdl/ddmd_pkg.sv */
`default_nettype none
package ddmd_pkg;

  localparam int PIXELS_DEF = 25;
  localparam int GLYPH_BITS = 13;
  localparam int POS_W = 6;
  localparam int QDEPTH = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [1:0] OP_UP = 2'd0;
  localparam logic [1:0] OP_DOWN = 2'd1;
  localparam logic [1:0] OP_REDRAW = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 1'd1;

  localparam logic [15:0] DEBOUNCE_RST = 16'd200;
  localparam logic [7:0] GREEN_RST = 8'd10;

  localparam logic [POS_W-1:0] GLYPH_POS [GLYPH_BITS] = '{
    6'd1, 6'd2, 6'd3, 6'd8, 6'd6, 6'd11, 6'd12, 6'd13, 6'd18, 6'd16, 6'd21, 6'd22, 6'd23
  };

  typedef struct packed {
    logic [3:0] digit;
  } ddmd_job_t;

  function automatic logic [GLYPH_BITS-1:0] glyph_of(input logic [3:0] digit);
    logic [GLYPH_BITS-1:0] pat;
    unique case (digit)
      4'd0: pat = 13'h1FBF;
      4'd1: pat = 13'h0529;
      4'd2: pat = 13'h1DF7;
      4'd3: pat = 13'h1DEF;
      4'd4: pat = 13'h17E9;
      4'd5: pat = 13'h1EEF;
      4'd6: pat = 13'h1EFF;
      4'd7: pat = 13'h1D29;
      4'd8: pat = 13'h1FFF;
      4'd9: pat = 13'h1FEF;
      default: pat = '0;
    endcase
    return pat;
  endfunction

  // one compare per glyph bit, positions are distinct
  function automatic logic pixel_lit(input logic [GLYPH_BITS-1:0] pat,
                                     input logic [POS_W-1:0] idx);
    logic hit;
    hit = 1'b0;
    for (int j = 0; j < GLYPH_BITS; j++) begin
      if (pat[j] && (GLYPH_POS[j] == idx)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

/* hdl/debounced_digit_matrix_driver.sv */
// channel   | dir | handshake                   | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: opcode[1:0], now_ms[33:2]
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: pixel_index[4:0],
//           |     |                             |   pixel_word[36:5]; tlast: last
// cfg       | in  | cfg_we                      | cfg_addr, cfg_wdata
//
// a frame leaves at one word per cycle while the output is ready, PIXELS words,
// once the idle back end picks up its job from the queue; the pixel counter sets the pace.
// an input beat is taken whenever the two-entry job queue has room, so
// presses keep being classified while a frame drains.
// synchronous reset clears digit, last press time, queue and sender.
// output stalls hold the word register; the sender waits on it.
`default_nettype none
module debounced_digit_matrix_driver
  import ddmd_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // opcode, now_ms, zero pad
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // pixel_index, pixel_word, zero pad
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [15:0] debounce_ms;
  logic [7:0]  green_level;
  logic        q_full;
  logic        q_not_empty;
  logic        push;
  logic        pop;
  ddmd_job_t   push_job;
  ddmd_job_t   q_head;
  logic [4:0]  pixel_index;
  logic [31:0] pixel_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RST;
      green_level <= GREEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE: debounce_ms <= cfg_wdata[15:0];
        REG_GREEN: green_level <= cfg_wdata[7:0];
        default: green_level <= green_level;
      endcase
    end
  end

  ddmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .opcode      (s_axis_tdata[1:0]),
    .now_ms      (s_axis_tdata[33:2]),
    .debounce_ms (debounce_ms),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  ddmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ddmd_back #(.PIXELS(PIXELS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .green_level (green_level),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .pixel_index (pixel_index),
    .pixel_word  (pixel_word),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, pixel_word, pixel_index};

endmodule
`default_nettype wire

/* hdl/ddmd_front.sv */
`default_nettype none
module ddmd_front
  import ddmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] debounce_ms,
  input  wire logic        q_full,
  output logic             push,
  output ddmd_job_t        push_job
);

  logic [3:0]  digit;
  logic [3:0]  digit_next;
  logic [31:0] last_press_ms;
  logic [31:0] last_press_ms_next;
  logic [31:0] diff;
  logic        accept;
  logic        pass;
  logic        moved;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign diff = now_ms - last_press_ms;
  assign pass = diff > {16'd0, debounce_ms};

  always_comb begin
    digit_next = digit;
    last_press_ms_next = last_press_ms;
    moved = 1'b0;
    unique case (opcode)
      OP_UP: begin
        if (pass) begin
          last_press_ms_next = now_ms;
          if (digit != 4'd9) begin
            digit_next = digit + 4'd1;
            moved = 1'b1;
          end
        end
      end
      OP_DOWN: begin
        if (pass) begin
          last_press_ms_next = now_ms;
          if (digit != 4'd0) begin
            digit_next = digit - 4'd1;
            moved = 1'b1;
          end
        end
      end
      OP_REDRAW: moved = 1'b1;
      OP_UNUSED: moved = 1'b0;
      default: moved = 1'b0;
    endcase
  end

  assign push = accept && moved;
  assign push_job.digit = digit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= 4'd0;
      last_press_ms <= 32'd0;
    end else if (accept) begin
      digit <= digit_next;
      last_press_ms <= last_press_ms_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/ddmd_queue.sv */
`default_nettype none
module ddmd_queue
  import ddmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire ddmd_job_t push_job,
  input  wire logic      pop,
  output logic           full,
  output logic           not_empty,
  output ddmd_job_t      head
);

  localparam int PW = $clog2(QDEPTH);

  ddmd_job_t         mem [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign full = count == (PW+1)'(QDEPTH);
  assign not_empty = count != '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/ddmd_back.sv */
`default_nettype none
module ddmd_back
  import ddmd_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_not_empty,
  input  wire ddmd_job_t q_head,
  output logic           pop,
  input  wire logic [7:0] green_level,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [4:0]     pixel_index,
  output logic [31:0]    pixel_word,
  output logic           last
);

  localparam int CW = $clog2(PIXELS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [3:0]    cur_digit;
  logic          advance;
  logic          final_word;
  logic          lit;

  assign advance = !out_valid || out_ready;
  assign pop = !busy && q_not_empty;
  assign final_word = cnt == CW'(PIXELS - 1);
  assign lit = pixel_lit(glyph_of(cur_digit), POS_W'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= busy;
      if (busy && advance) begin
        if (final_word) busy <= 1'b0;
        else cnt <= cnt + 1'b1;
      end else if (pop) begin
        busy <= 1'b1;
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_digit <= q_head.digit;
    if (busy && advance) begin
      pixel_index <= 5'(cnt);
      pixel_word <= {(lit ? green_level : 8'd0), 24'd0};
      last <= final_word;
    end
  end

endmodule
`default_nettype wire

/* hdl/ddmd_checker.sv */
`default_nettype none
module ddmd_checker
  import ddmd_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast
);

  // final word of a frame sits at the last matrix position
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == 5'(PIXELS - 1))
    else $error("tlast on wrong pixel");

  // inside a frame the next word follows at once with the next index
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[4:0] == $past(m_axis_tdata[4:0]) + 5'd1)
    else $error("gap or skip inside frame");

  // red, blue, low byte and the top pad bits are always zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[28:5] == 24'd0 && m_axis_tdata[39:37] == 3'd0)
    else $error("nonzero red, blue or pad");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled beat changed");

endmodule

bind debounced_digit_matrix_driver ddmd_checker #(.PIXELS(PIXELS)) u_ddmd_checker (.*);
`default_nettype wire

/* bench/tb_debounced_digit_matrix_driver.sv */
module tb_debounced_digit_matrix_driver;
  import ddmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN = PIXELS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 64;

  // glyph bit k lights matrix position SHAPE_SPOTS[k]
  localparam logic [12:0] DIGIT_SHAPES [10] = '{
    13'h1FBF, 13'h0529, 13'h1DF7, 13'h1DEF, 13'h17E9,
    13'h1EEF, 13'h1EFF, 13'h1D29, 13'h1FFF, 13'h1FEF
  };
  localparam int SHAPE_SPOTS [13] = '{1, 2, 3, 8, 6, 11, 12, 13, 18, 16, 21, 22, 23};

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_COIN} ready_style_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] word;
    logic        tail;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // opcode, now_ms, zero pad
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // pixel_index, pixel_word, zero pad
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [3:0]  shown_digit;
  logic [31:0] press_stamp_ms;
  logic [15:0] debounce_win;
  logic [7:0]  green_lvl;

  pixel_beat_t frame_words_due [$];
  int fail_count = 0;
  int cycle_count = 0;
  int stall_phase = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b0;
  ready_style_t ready_style = READY_ALWAYS;
  logic [31:0] clock_ms;

  debounced_digit_matrix_driver #(.PIXELS(FRAME_LEN)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_debounced_digit_matrix_driver: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (ready_style)
      READY_ALWAYS:   m_axis_tready <= 1'b1;
      READY_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      READY_PERIODIC: m_axis_tready <= ((stall_phase % 11) < 7);
      default:        m_axis_tready <= $urandom_range(0, 1);
    endcase
    stall_phase <= stall_phase + 1;
  end

  always @(posedge clk) begin
    pixel_beat_t got;
    pixel_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.idx = m_axis_tdata[4:0];
      got.word = m_axis_tdata[36:5];
      got.tail = m_axis_tlast;
      if (frame_words_due.size() == 0) begin
        $error("unexpected beat: pixel_index %0d pixel_word %h last %0b",
               got.idx, got.word, got.tail);
        fail_count++;
      end else begin
        want = frame_words_due.pop_front();
        if (got.idx !== want.idx) begin
          $error("pixel_index: expected %0d, got %0d", want.idx, got.idx);
          fail_count++;
        end
        if (got.word !== want.word) begin
          $error("pixel_word: expected %h, got %h", want.word, got.word);
          fail_count++;
        end
        if (got.tail !== want.tail) begin
          $error("last: expected %0b, got %0b", want.tail, got.tail);
          fail_count++;
        end
      end
    end
  end

  task automatic push_frame_words();
    logic [12:0] shape;
    pixel_beat_t beat;
    logic lit;
    shape = DIGIT_SHAPES[shown_digit];
    for (int k = 0; k < FRAME_LEN; k++) begin
      lit = 1'b0;
      for (int j = 0; j < 13; j++) begin
        if (shape[j] && SHAPE_SPOTS[j] == k) lit = 1'b1;
      end
      beat.idx = k[4:0];
      beat.word = lit ? {green_lvl, 24'd0} : 32'd0;
      beat.tail = (k == FRAME_LEN - 1);
      frame_words_due.push_back(beat);
    end
  endtask

  task automatic apply_button_event(input logic [1:0] op, input logic [31:0] t);
    logic moved;
    logic [31:0] since;
    moved = 1'b0;
    case (op)
      OP_REDRAW: push_frame_words();
      OP_UP, OP_DOWN: begin
        since = t - press_stamp_ms;
        if (since > {16'd0, debounce_win}) begin
          if (op == OP_UP && shown_digit != 4'd9) begin
            shown_digit = shown_digit + 4'd1;
            moved = 1'b1;
          end else if (op == OP_DOWN && shown_digit != 4'd0) begin
            shown_digit = shown_digit - 4'd1;
            moved = 1'b1;
          end
          press_stamp_ms = t;
        end
        if (moved) push_frame_words();
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tdata <= {{(IN_TDATA_W - 34){1'b0}}, t, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_button_event(op, t);
  endtask

  // each write drops the enable and waits before returning, which keeps the enable edges apart
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_addr <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE: debounce_win = val;
      REG_GREEN:    green_lvl = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain every due word, then let the design idle before the next test
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_presses();
    ready_style = READY_ALWAYS;
    sender_gaps = 1'b0;
    send_item(OP_REDRAW, 32'd0);
    send_item(OP_DOWN, 32'd50);             // inside window
    send_item(OP_DOWN, 32'd201);            // accepted at zero, stamp only
    send_item(OP_UP, 32'd300);
    send_item(OP_UP, 32'd401);              // exactly the window, rejected
    send_item(OP_UP, 32'd402);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    for (int i = 1; i <= 8; i++) send_item(OP_UP, 32'd402 + 32'd201 * i);
    send_item(OP_UP, 32'd2211);             // at nine, stamp only
    send_item(OP_REDRAW, 32'd0);
    send_item(OP_DOWN, 32'hFFFF_FF00);
    send_item(OP_DOWN, 32'h0000_0010);      // wraps past zero
    send_item(OP_DOWN, 32'h0000_0010 + 32'd200);
    send_item(OP_UNUSED, 32'd0);
    settle_idle();
  endtask

  task automatic test_config_extremes();
    ready_style = READY_COIN;
    sender_gaps = 1'b1;
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_GREEN, 16'd255);
    send_item(OP_UP, 32'd5000);
    send_item(OP_UP, 32'd5000);
    send_item(OP_UP, 32'd5001);
    send_item(OP_REDRAW, 32'd5001);
    settle_idle();
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_GREEN, 16'd0);
    send_item(OP_DOWN, 32'd5001 + 32'd65535);
    send_item(OP_DOWN, 32'd5001 + 32'd65536);
    send_item(OP_REDRAW, 32'hAAAA_5555);
    settle_idle();
  endtask

  task automatic test_random_traffic();
    int counted;
    int pick;
    logic [1:0] op;
    logic [31:0] t;
    logic [15:0] win;
    logic [7:0] lvl;
    clock_ms = press_stamp_ms;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        win = 16'd0;
        lvl = 8'd255;
      end else if (ph == 1) begin
        win = 16'hFFFF;
        lvl = 8'd0;
      end else begin
        win = (ph % 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(1, 300));
        lvl = 8'($urandom_range(0, 255));
      end
      write_reg(REG_DEBOUNCE, win);
      write_reg(REG_GREEN, {8'd0, lvl});
      ready_style = ready_style_t'(ph % 4);
      sender_gaps = (ph % 3 != 0);
      counted = 0;
      while (counted < 50) begin
        pick = $urandom_range(0, 99);
        op = ($urandom_range(0, 99) < 55) ? OP_UP : OP_DOWN;
        if (pick < 60) begin
          clock_ms = clock_ms + win + 32'd1 + $urandom_range(0, 100);
          t = clock_ms;
        end else if (pick < 75) begin
          // bounce within the window
          t = clock_ms + $urandom_range(0, win);
        end else if (pick < 85) begin
          op = OP_REDRAW;
          t = $urandom();
        end else if (pick < 93) begin
          clock_ms = $urandom();
          t = clock_ms;
        end else begin
          op = OP_UNUSED;
          t = $urandom();
        end
        send_item(op, t);
        if (op != OP_UNUSED) counted++;
      end
      settle_idle();
    end
  endtask

  initial begin
    shown_digit = 4'd0;
    press_stamp_ms = 32'd0;
    debounce_win = DEBOUNCE_RST;
    green_lvl = GREEN_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_presses();
    test_config_extremes();
    test_random_traffic();
    settle_idle();
    if (frame_words_due.size() != 0) begin
      $error("frame words still due at end: %0d", frame_words_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_debounced_digit_matrix_driver: clean");
    end else begin
      $display("tb_debounced_digit_matrix_driver: errors");
    end
    $finish;
  end

endmodule
